@@ sv/gqtl_pkg.sv @@
package gqtl_pkg;

  // command codes of an input item
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_CHAR  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // special character codes
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam int unsigned CHAR_FIRST  = 32;

  localparam int unsigned TEX_W = 17;
  localparam int unsigned POS_W = 32;
  localparam int unsigned QUAD_W = 16;

  // work kinds handed from the front end to the back end
  typedef enum logic [1:0] {
    OP_GLYPH,
    OP_BAD,
    OP_START,
    OP_NEWLINE
  } op_e;

  // one glyph table entry
  typedef struct packed {
    logic        [TEX_W-1:0] tex_left;
    logic        [TEX_W-1:0] tex_top;
    logic        [TEX_W-1:0] tex_right;
    logic        [TEX_W-1:0] tex_bottom;
    logic signed [POS_W-1:0] box_x0;
    logic signed [POS_W-1:0] box_y0;
    logic signed [POS_W-1:0] box_x1;
    logic signed [POS_W-1:0] box_y1;
    logic signed [POS_W-1:0] advance;
  } glyph_t;

  localparam int unsigned GLYPH_W = $bits(glyph_t);

  // queued work: kind plus the glyph entry read for it
  typedef struct packed {
    op_e    kind;
    glyph_t glyph;
  } op_t;

  // one result item
  typedef struct packed {
    logic signed [POS_W-1:0]  x_left;
    logic signed [POS_W-1:0]  x_right;
    logic signed [POS_W-1:0]  y_lower;
    logic signed [POS_W-1:0]  y_upper;
    logic        [TEX_W-1:0]  u_left;
    logic        [TEX_W-1:0]  v_top;
    logic        [TEX_W-1:0]  u_right;
    logic        [TEX_W-1:0]  v_bottom;
    logic        [QUAD_W-1:0] quad_number;
    logic                     last;
    logic                     bad_char;
  } res_t;

  // clamp a 33-bit sum to the signed 32-bit range
  function automatic logic signed [POS_W-1:0] sat33(input logic signed [POS_W:0] s);
    logic signed [POS_W-1:0] r;
    if (s[POS_W] != s[POS_W-1]) begin
      r = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = s[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] a,
                                                      input logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] s;
    s = {a[POS_W-1], a} + {b[POS_W-1], b};
    return sat33(s);
  endfunction

  function automatic logic signed [POS_W-1:0] sat_sub(input logic signed [POS_W-1:0] a,
                                                      input logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] s;
    s = {a[POS_W-1], a} - {b[POS_W-1], b};
    return sat33(s);
  endfunction

endpackage

@@ sv/gqtl_if.sv @@
// input item channel
interface gqtl_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  char_code;
  logic [6:0]  glyph_slot;
  logic [16:0] tex_left;
  logic [16:0] tex_top;
  logic [16:0] tex_right;
  logic [16:0] tex_bottom;
  logic signed [31:0] box_x0;
  logic signed [31:0] box_y0;
  logic signed [31:0] box_x1;
  logic signed [31:0] box_y1;
  logic signed [31:0] advance;

  modport source (
    output valid, cmd, char_code, glyph_slot, tex_left, tex_top, tex_right, tex_bottom,
           box_x0, box_y0, box_x1, box_y1, advance,
    input  ready
  );
  modport sink (
    input  valid, cmd, char_code, glyph_slot, tex_left, tex_top, tex_right, tex_bottom,
           box_x0, box_y0, box_x1, box_y1, advance,
    output ready
  );
endinterface

// result quad channel
interface gqtl_quad_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] x_left;
  logic signed [31:0] x_right;
  logic signed [31:0] y_lower;
  logic signed [31:0] y_upper;
  logic [16:0] u_left;
  logic [16:0] v_top;
  logic [16:0] u_right;
  logic [16:0] v_bottom;
  logic [15:0] quad_number;
  logic        last;
  logic        bad_char;

  modport source (
    output valid, x_left, x_right, y_lower, y_upper, u_left, v_top, u_right, v_bottom,
           quad_number, last, bad_char,
    input  ready
  );
  modport sink (
    input  valid, x_left, x_right, y_lower, y_upper, u_left, v_top, u_right, v_bottom,
           quad_number, last, bad_char,
    output ready
  );
endinterface

@@ sv/gqtl_ram.sv @@
module gqtl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/gqtl_front.sv @@
module gqtl_front #(
  parameter int unsigned GLYPH_COUNT = 96,
  parameter int unsigned TAB_STOP = 4,
  localparam int unsigned AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1,
  localparam int unsigned CW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  gqtl_item_if.sink       item_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output gqtl_pkg::op_t   push_op_o,
  output logic [CW-1:0]   push_last_o
);

  logic                 accept;
  logic                 is_op;
  logic                 wr_en;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  gqtl_pkg::op_e        kind;
  logic [CW-1:0]        last_idx;
  logic [CW-1:0]        col_d, col_q;
  logic                 s1_v_d, s1_v_q;
  gqtl_pkg::op_e        s1_kind_q;
  logic [CW-1:0]        s1_last_q;
  gqtl_pkg::glyph_t     wdata;
  logic [gqtl_pkg::GLYPH_W-1:0] rdata;

  assign item_i.ready = !s1_v_q || push_ready_i;
  assign accept       = item_i.valid && item_i.ready;

  // classify the incoming item and pick the table access
  always_comb begin
    is_op    = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    kind     = gqtl_pkg::OP_BAD;
    last_idx = '0;
    col_d    = col_q;
    unique case (item_i.cmd)
      gqtl_pkg::CMD_LOAD: begin
        wr_en = 32'(item_i.glyph_slot) < GLYPH_COUNT;
      end
      gqtl_pkg::CMD_START: begin
        is_op = 1'b1;
        kind  = gqtl_pkg::OP_START;
        col_d = '0;
      end
      gqtl_pkg::CMD_CHAR: begin
        is_op = 1'b1;
        if (item_i.char_code == gqtl_pkg::CHAR_NEWLINE) begin
          kind  = gqtl_pkg::OP_NEWLINE;
          col_d = '0;
        end else if (item_i.char_code == gqtl_pkg::CHAR_TAB) begin
          // space quads up to the next tab stop
          kind     = gqtl_pkg::OP_GLYPH;
          rd_en    = 1'b1;
          last_idx = CW'(TAB_STOP - 1) - col_q;
          col_d    = '0;
        end else if (32'(item_i.char_code) >= gqtl_pkg::CHAR_FIRST &&
                     32'(item_i.char_code) < gqtl_pkg::CHAR_FIRST + GLYPH_COUNT) begin
          kind    = gqtl_pkg::OP_GLYPH;
          rd_en   = 1'b1;
          rd_addr = AW'(32'(item_i.char_code) - gqtl_pkg::CHAR_FIRST);
          col_d   = (col_q == CW'(TAB_STOP - 1)) ? '0 : col_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign wdata.tex_left   = item_i.tex_left;
  assign wdata.tex_top    = item_i.tex_top;
  assign wdata.tex_right  = item_i.tex_right;
  assign wdata.tex_bottom = item_i.tex_bottom;
  assign wdata.box_x0     = item_i.box_x0;
  assign wdata.box_y0     = item_i.box_y0;
  assign wdata.box_x1     = item_i.box_x1;
  assign wdata.box_y1     = item_i.box_y1;
  assign wdata.advance    = item_i.advance;

  // glyph table
  gqtl_ram #(
    .WIDTH (gqtl_pkg::GLYPH_W),
    .DEPTH (GLYPH_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (accept && wr_en),
    .waddr_i (AW'(item_i.glyph_slot)),
    .wdata_i (wdata),
    .re_i    (accept && rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // stage waiting on the table read
  always_comb begin
    s1_v_d = s1_v_q;
    if (accept) begin
      s1_v_d = is_op;
    end else if (push_ready_i) begin
      s1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      col_q  <= '0;
    end else begin
      s1_v_q <= s1_v_d;
      if (accept) begin
        col_q <= col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q <= kind;
      s1_last_q <= last_idx;
    end
  end

  assign push_valid_o    = s1_v_q;
  assign push_op_o.kind  = s1_kind_q;
  assign push_op_o.glyph = gqtl_pkg::glyph_t'(rdata);
  assign push_last_o     = s1_last_q;

endmodule

@@ sv/gqtl_back.sv @@
module gqtl_back #(
  parameter int unsigned TAB_STOP = 4,
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned CW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  gqtl_pkg::op_t push_op_i,
  input  logic [CW-1:0] push_last_i,
  gqtl_quad_if.source   quad_o
);

  localparam logic signed [31:0] PenOne = 32'(64'd1 << FRAC_BITS);

  // two-entry queue between front and back
  gqtl_pkg::op_t  ent_q  [2];
  logic [CW-1:0]  elast_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop, head_v;
  gqtl_pkg::op_t  head;
  logic [CW-1:0]  head_last;

  logic signed [31:0] pen_x_d, pen_x_q;
  logic signed [31:0] pen_y_d, pen_y_q;
  logic [15:0]        quad_d, quad_q;
  logic [CW-1:0]      rep_d, rep_q;
  logic               can_emit, emit;
  logic               out_v_q;
  gqtl_pkg::res_t     res_d, res_q;

  assign push_ready_o = cnt_q != 2'd2;
  assign push         = push_valid_i && push_ready_o;
  assign head_v       = cnt_q != 2'd0;
  assign head         = ent_q[rd_ptr_q];
  assign head_last    = elast_q[rd_ptr_q];
  assign can_emit     = !out_v_q || quad_o.ready;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q]   <= push_op_i;
      elast_q[wr_ptr_q] <= push_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // carry out the head of the queue
  always_comb begin
    pop     = 1'b0;
    emit    = 1'b0;
    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    quad_d  = quad_q;
    rep_d   = rep_q;
    res_d   = '0;
    if (head_v) begin
      unique case (head.kind)
        gqtl_pkg::OP_GLYPH: begin
          if (can_emit) begin
            emit              = 1'b1;
            res_d.x_left      = gqtl_pkg::sat_add(pen_x_q, head.glyph.box_x0);
            res_d.x_right     = gqtl_pkg::sat_add(pen_x_q, head.glyph.box_x1);
            res_d.y_lower     = gqtl_pkg::sat_sub(pen_y_q, head.glyph.box_y1);
            res_d.y_upper     = gqtl_pkg::sat_sub(pen_y_q, head.glyph.box_y0);
            res_d.u_left      = head.glyph.tex_left;
            res_d.v_top       = head.glyph.tex_top;
            res_d.u_right     = head.glyph.tex_right;
            res_d.v_bottom    = head.glyph.tex_bottom;
            res_d.quad_number = quad_q;
            res_d.last        = rep_q == head_last;
            quad_d            = quad_q + 16'd1;
            pen_x_d           = gqtl_pkg::sat_add(pen_x_q, head.glyph.advance);
            if (rep_q == head_last) begin
              pop   = 1'b1;
              rep_d = '0;
            end else begin
              rep_d = rep_q + CW'(1);
            end
          end
        end
        gqtl_pkg::OP_BAD: begin
          if (can_emit) begin
            emit           = 1'b1;
            pop            = 1'b1;
            res_d.last     = 1'b1;
            res_d.bad_char = 1'b1;
          end
        end
        gqtl_pkg::OP_START: begin
          pop     = 1'b1;
          pen_x_d = '0;
          pen_y_d = PenOne;
          quad_d  = '0;
        end
        gqtl_pkg::OP_NEWLINE: begin
          pop     = 1'b1;
          pen_x_d = '0;
          pen_y_d = gqtl_pkg::sat_sub(pen_y_q, PenOne);
        end
      endcase
    end
  end

  // pen state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q <= '0;
      pen_y_q <= PenOne;
      quad_q  <= '0;
      rep_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      pen_x_q <= pen_x_d;
      pen_y_q <= pen_y_d;
      quad_q  <= quad_d;
      rep_q   <= rep_d;
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (quad_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign quad_o.valid       = out_v_q;
  assign quad_o.x_left      = res_q.x_left;
  assign quad_o.x_right     = res_q.x_right;
  assign quad_o.y_lower     = res_q.y_lower;
  assign quad_o.y_upper     = res_q.y_upper;
  assign quad_o.u_left      = res_q.u_left;
  assign quad_o.v_top       = res_q.v_top;
  assign quad_o.u_right     = res_q.u_right;
  assign quad_o.v_bottom    = res_q.v_bottom;
  assign quad_o.quad_number = res_q.quad_number;
  assign quad_o.last        = res_q.last;
  assign quad_o.bad_char    = res_q.bad_char;

endmodule

@@ sv/glyph_quad_text_layout_unit.sv @@
// Bitmap-font text layout: glyph table loads, start, and character items come in on
// item_i; every printable character gives one quad on quad_o, a tab gives space quads up
// to the next tab stop (one per cycle while quad_o is ready, at most TAB_STOP of them), a
// newline or a start gives no quad, and an illegal code gives one quad with bad_char set.
// The front end takes one item per cycle unless its item waits on a full queue, reads the
// glyph table RAM (registered read), and a quad passes the queue and the output register;
// the back end retires one queued command or emits one quad per cycle while quad_o is
// ready, so the sustained rate is one item per cycle for plain text and one quad per cycle
// for tabs. The glyph table is not cleared at reset: load every entry that text will use.
module glyph_quad_text_layout_unit #(
  parameter int unsigned GLYPH_COUNT = 96,
  parameter int unsigned TAB_STOP = 4,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gqtl_item_if.sink   item_i,
  gqtl_quad_if.source quad_o
);

  localparam int unsigned CW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

  logic          push_valid;
  logic          push_ready;
  gqtl_pkg::op_t push_op;
  logic [CW-1:0] push_last;

  // classify and look up glyphs
  gqtl_front #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .TAB_STOP    (TAB_STOP)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_op_o    (push_op),
    .push_last_o  (push_last)
  );

  // pen tracking and quad output
  gqtl_back #(
    .TAB_STOP  (TAB_STOP),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_op_i    (push_op),
    .push_last_i  (push_last),
    .quad_o       (quad_o)
  );

  // input stalls only while a looked-up item waits for the queue
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_i.ready |-> push_valid && !push_ready)
    else $error("input stalled without a waiting front item");

  // a front item is never dropped before the queue takes it
  a_push_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid && !push_ready |=> push_valid)
    else $error("front item lost while queue full");

  // an illegal-code result is a lone, empty result
  a_bad_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quad_o.valid && quad_o.bad_char |->
      quad_o.last && quad_o.quad_number == 16'd0 && quad_o.x_left == 32'sd0)
    else $error("illegal-code result not empty");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

localparam int unsigned LAYOUT_GLYPHS = 96;
localparam int unsigned LAYOUT_TAB_STOP = 4;
localparam int unsigned LAYOUT_FRAC = 16;
localparam logic signed [31:0] LAYOUT_ONE = 32'sh0001_0000;

// one item as offered on the item channel
typedef struct packed {
  logic [1:0]       cmd;
  logic [7:0]       code;
  logic [6:0]       slot;
  gqtl_pkg::glyph_t glyph;
} text_item_t;

// pen, column and glyph table as the block should hold them, and the quads still owed
class layout_tracker;
  gqtl_pkg::glyph_t  glyphs[LAYOUT_GLYPHS];
  logic signed [31:0] pen_x;
  logic signed [31:0] pen_y;
  int unsigned        column;
  logic [15:0]        quad_count;
  gqtl_pkg::res_t     owed[$];
  int unsigned        mismatches;

  function new();
    pen_x = '0;
    pen_y = LAYOUT_ONE;
    column = 0;
    quad_count = '0;
    mismatches = 0;
  endfunction

  function logic signed [31:0] clamp(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // place one glyph box at the pen, then step the pen by the glyph's advance
  function void place_glyph(int unsigned idx, bit is_last);
    gqtl_pkg::glyph_t g;
    gqtl_pkg::res_t   q;
    g = glyphs[idx];
    q.x_left = clamp(longint'(pen_x) + longint'($signed(g.box_x0)));
    q.x_right = clamp(longint'(pen_x) + longint'($signed(g.box_x1)));
    q.y_lower = clamp(longint'(pen_y) - longint'($signed(g.box_y1)));
    q.y_upper = clamp(longint'(pen_y) - longint'($signed(g.box_y0)));
    q.u_left = g.tex_left;
    q.v_top = g.tex_top;
    q.u_right = g.tex_right;
    q.v_bottom = g.tex_bottom;
    q.quad_number = quad_count;
    q.last = is_last;
    q.bad_char = 1'b0;
    owed.push_back(q);
    quad_count = quad_count + 16'd1;
    pen_x = clamp(longint'(pen_x) + longint'($signed(g.advance)));
  endfunction

  // work out the quads caused by one accepted item
  function void take_item(text_item_t it);
    gqtl_pkg::res_t q;
    int unsigned    n;
    case (it.cmd)
      gqtl_pkg::CMD_LOAD: begin
        if (it.slot < LAYOUT_GLYPHS) glyphs[it.slot] = it.glyph;
      end
      gqtl_pkg::CMD_START: begin
        pen_x = '0;
        pen_y = LAYOUT_ONE;
        column = 0;
        quad_count = '0;
      end
      gqtl_pkg::CMD_CHAR: begin
        if (it.code == gqtl_pkg::CHAR_NEWLINE) begin
          pen_x = '0;
          pen_y = clamp(longint'(pen_y) - longint'(LAYOUT_ONE));
          column = 0;
        end else if (it.code == gqtl_pkg::CHAR_TAB) begin
          n = LAYOUT_TAB_STOP - column;
          for (int unsigned k = 0; k < n; k++) place_glyph(0, k + 1 == n);
          column = 0;
        end else if (it.code >= gqtl_pkg::CHAR_FIRST &&
                     it.code < gqtl_pkg::CHAR_FIRST + LAYOUT_GLYPHS) begin
          place_glyph(it.code - gqtl_pkg::CHAR_FIRST, 1'b1);
          column = (column + 1) % LAYOUT_TAB_STOP;
        end else begin
          q = '0;
          q.last = 1'b1;
          q.bad_char = 1'b1;
          owed.push_back(q);
        end
      end
      default: ;
    endcase
  endfunction

  function void compare(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // match a quad leaving the block against the oldest one owed
  function void check_quad(gqtl_pkg::res_t got);
    gqtl_pkg::res_t want;
    if (owed.size() == 0) begin
      $display("%0t: quad with none owed, expected nothing, got %h", $time, got);
      mismatches++;
      return;
    end
    want = owed.pop_front();
    compare("x_left", want.x_left, got.x_left);
    compare("x_right", want.x_right, got.x_right);
    compare("y_lower", want.y_lower, got.y_lower);
    compare("y_upper", want.y_upper, got.y_upper);
    compare("u_left", want.u_left, got.u_left);
    compare("v_top", want.v_top, got.v_top);
    compare("u_right", want.u_right, got.u_right);
    compare("v_bottom", want.v_bottom, got.v_bottom);
    compare("quad_number", want.quad_number, got.quad_number);
    compare("last", want.last, got.last);
    compare("bad_char", want.bad_char, got.bad_char);
  endfunction
endclass

module testbench;
  import gqtl_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 340;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam logic [1:0]  CMD_SPARE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gqtl_item_if item_if ();
  gqtl_quad_if quad_if ();

  glyph_quad_text_layout_unit #(
    .GLYPH_COUNT (LAYOUT_GLYPHS),
    .TAB_STOP    (LAYOUT_TAB_STOP),
    .FRAC_BITS   (LAYOUT_FRAC)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if),
    .quad_o (quad_if)
  );

  layout_tracker tracker;
  int unsigned   gap_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   cycle_count = 0;
  bit            loaded[LAYOUT_GLYPHS];

  always #4 clk_i = ~clk_i;

  // receiver stalls
  always @(posedge clk_i) begin
    quad_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // quads leaving the block
  always @(posedge clk_i) begin
    if (rst_ni && quad_if.valid && quad_if.ready) begin
      tracker.check_quad('{x_left: quad_if.x_left, x_right: quad_if.x_right,
                           y_lower: quad_if.y_lower, y_upper: quad_if.y_upper,
                           u_left: quad_if.u_left, v_top: quad_if.v_top,
                           u_right: quad_if.u_right, v_bottom: quad_if.v_bottom,
                           quad_number: quad_if.quad_number, last: quad_if.last,
                           bad_char: quad_if.bad_char});
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic logic [16:0] tex_coord();
    return ($urandom_range(7) == 0) ? 17'h10000 : 17'($urandom_range(65535));
  endfunction

  // mostly glyph-sized values, now and then the ends of the range
  function automatic logic [31:0] coord(bit wild);
    if (wild) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        default: return $urandom;
      endcase
    end
    return 32'($urandom_range(0, 32'h0018_0000)) - 32'h0008_0000;
  endfunction

  function automatic glyph_t random_glyph();
    glyph_t g;
    bit     wild;
    wild = ($urandom_range(9) == 0);
    g.tex_left = tex_coord();
    g.tex_top = tex_coord();
    g.tex_right = tex_coord();
    g.tex_bottom = tex_coord();
    g.box_x0 = coord(wild);
    g.box_y0 = coord(wild);
    g.box_x1 = coord(wild);
    g.box_y1 = coord(wild);
    g.advance = coord(wild);
    return g;
  endfunction

  function automatic text_item_t make_item(logic [1:0] cmd, logic [7:0] code,
                                           logic [6:0] slot);
    text_item_t it;
    it.cmd = cmd;
    it.code = code;
    it.slot = slot;
    it.glyph = random_glyph();
    return it;
  endfunction

  function automatic logic [7:0] illegal_code();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (c == CHAR_TAB || c == CHAR_NEWLINE ||
               (c >= CHAR_FIRST && c < CHAR_FIRST + LAYOUT_GLYPHS));
    return c;
  endfunction

  // offer one item, with a random gap first, and note it once transferred
  task automatic send_item(text_item_t it);
    if ($urandom_range(99) < gap_pct) begin
      item_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    item_if.valid <= 1'b1;
    item_if.cmd <= it.cmd;
    item_if.char_code <= it.code;
    item_if.glyph_slot <= it.slot;
    item_if.tex_left <= it.glyph.tex_left;
    item_if.tex_top <= it.glyph.tex_top;
    item_if.tex_right <= it.glyph.tex_right;
    item_if.tex_bottom <= it.glyph.tex_bottom;
    item_if.box_x0 <= it.glyph.box_x0;
    item_if.box_y0 <= it.glyph.box_y0;
    item_if.box_x1 <= it.glyph.box_x1;
    item_if.box_y1 <= it.glyph.box_y1;
    item_if.advance <= it.glyph.advance;
    do @(posedge clk_i); while (!item_if.ready);
    tracker.take_item(it);
    if (it.cmd == CMD_LOAD && it.slot < LAYOUT_GLYPHS) loaded[it.slot] = 1'b1;
  endtask

  task automatic send_char(logic [7:0] code);
    send_item(make_item(CMD_CHAR, code, 7'($urandom_range(127))));
  endtask

  task automatic send_cmd(logic [1:0] cmd);
    send_item(make_item(cmd, 8'($urandom_range(255)), 7'($urandom_range(127))));
  endtask

  task automatic send_load(logic [6:0] slot, glyph_t g);
    text_item_t it;
    it = make_item(CMD_LOAD, 8'($urandom_range(255)), slot);
    it.glyph = g;
    send_item(it);
  endtask

  initial begin
    glyph_t      g;
    logic [7:0]  bad_codes[6];
    int unsigned counted;
    int unsigned pick;
    int unsigned phase;
    logic [7:0]  code;
    logic [6:0]  slot;

    tracker = new();
    bad_codes = '{8'd0, 8'd8, 8'd11, 8'd31, 8'd128, 8'd255};
    item_if.valid = 1'b0;
    item_if.cmd = CMD_LOAD;
    item_if.char_code = '0;
    item_if.glyph_slot = '0;
    item_if.tex_left = '0;
    item_if.tex_top = '0;
    item_if.tex_right = '0;
    item_if.tex_bottom = '0;
    item_if.box_x0 = '0;
    item_if.box_y0 = '0;
    item_if.box_x1 = '0;
    item_if.box_y1 = '0;
    item_if.advance = '0;
    quad_if.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // space glyph, a glyph at the ends of every range, a glyph stepping left
    g = random_glyph();
    g.advance = 32'sh0008_0000;
    send_load(7'd0, g);
    g.tex_left = 17'h10000;
    g.tex_top = 17'h00000;
    g.tex_right = 17'h0ffff;
    g.tex_bottom = 17'h10000;
    g.box_x0 = 32'sh8000_0000;
    g.box_y0 = 32'sh7fff_ffff;
    g.box_x1 = 32'sh7fff_ffff;
    g.box_y1 = 32'sh8000_0000;
    g.advance = 32'sh7fff_ffff;
    send_load(7'd33, g);
    g = random_glyph();
    g.advance = 32'sh8000_0000;
    send_load(7'd95, g);
    // slots past the table are dropped, as is the spare command
    send_load(7'd96, random_glyph());
    send_load(7'd127, random_glyph());
    send_cmd(CMD_SPARE);

    // tabs from mid-column and from a tab stop, pen clamping both ways
    send_cmd(CMD_START);
    send_char(8'd32);
    send_char(CHAR_TAB);
    send_char(CHAR_TAB);
    send_char(8'd65);
    send_char(8'd65);
    send_char(8'd127);
    send_char(8'd127);
    send_char(8'd127);
    send_char(CHAR_NEWLINE);
    foreach (bad_codes[i]) send_char(bad_codes[i]);
    send_char(8'd32);
    send_char(8'd32);
    send_char(8'd32);
    send_char(CHAR_TAB);

    // a fresh text starting on a lower line
    send_cmd(CMD_START);
    send_char(CHAR_NEWLINE);
    send_char(8'd65);
    send_char(8'd32);
    send_cmd(CMD_START);

    // random text: mostly well-formed lines, with some noise and reloads
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      phase = counted * 4 / RANDOM_ITEMS;
      case (phase)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 61; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 61; end
        default: begin gap_pct = 26; stall_pct = 26; end
      endcase
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_cmd(CMD_START);
        counted++;
      end else if (pick < 11) begin
        if ($urandom_range(3) == 0) begin
          slot = 7'($urandom_range(LAYOUT_GLYPHS, 127));
        end else begin
          slot = 7'($urandom_range(LAYOUT_GLYPHS - 1));
          counted++;
        end
        send_load(slot, random_glyph());
      end else if (pick < 12) begin
        send_cmd(CMD_SPARE);
      end else begin
        pick = $urandom_range(99);
        if (pick < 72) begin
          code = 8'($urandom_range(CHAR_FIRST, CHAR_FIRST + LAYOUT_GLYPHS - 1));
          if (!loaded[code - CHAR_FIRST]) begin
            send_load(7'(code - CHAR_FIRST), random_glyph());
            counted++;
          end
          send_char(code);
        end else if (pick < 84) begin
          send_char(CHAR_TAB);
        end else if (pick < 92) begin
          send_char(CHAR_NEWLINE);
        end else begin
          send_char(illegal_code());
        end
        counted++;
      end
    end
    item_if.valid <= 1'b0;

    // drain the quads still owed, then allow for the pipeline
    while (tracker.owed.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.owed.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
